FILE: sv/ucf_pkg.sv
package ucf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 8;
    localparam int DIST_W   = 12;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int LIMIT_W  = 2 * DIST_W;

    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int UCOUNT_W = 5;

    // input word: center_x, center_y, radius from bit 0 up
    localparam int IN_DATA_W  = 32;
    localparam int CX_LSB     = 0;
    localparam int CY_LSB     = CX_LSB + COORD_W;
    localparam int RAD_LSB    = CY_LSB + COORD_W;

    // result word: status, slot, unique_count from bit 0 up
    localparam int OUT_DATA_W = 16;
    localparam int STATUS_LSB = 0;
    localparam int SLOT_LSB   = STATUS_LSB + STATUS_W;
    localparam int UCOUNT_LSB = SLOT_LSB + SLOT_W;
    localparam int OUT_USED_W = UCOUNT_LSB + UCOUNT_W;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(10);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_ACCEPTED  = 2'd0;
    localparam status_t STATUS_DUPLICATE = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_UNUSED    = 2'd3;

endpackage

FILE: sv/ucf_dist_unit.sv
module ucf_dist_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [ucf_pkg::COORD_W-1:0]       cx,
    input  logic [ucf_pkg::COORD_W-1:0]       cy,
    input  logic [ucf_pkg::COORD_W-1:0]       sx,
    input  logic [ucf_pkg::COORD_W-1:0]       sy,
    input  logic [ucf_pkg::LIMIT_W-1:0]       limit,
    output logic                              busy,
    output logic                              res_valid,
    output logic                              res_hit
);

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    logic [ucf_pkg::COORD_W-1:0]   dx_reg;
    logic [ucf_pkg::COORD_W-1:0]   dy_reg;
    logic [ucf_pkg::SQ_W-1:0]      sqx_reg;
    logic [ucf_pkg::SQ_W-1:0]      sqy_reg;
    logic                          hit_reg;
    logic [ucf_pkg::COORD_W-1:0]   dx_next;
    logic [ucf_pkg::COORD_W-1:0]   dy_next;
    logic [ucf_pkg::SQ_W:0]        sum;

    always_comb begin
        dx_next = (cx >= sx) ? (cx - sx) : (sx - cx);
        dy_next = (cy >= sy) ? (cy - sy) : (sy - cy);
        sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        // strict less-than: a center at exactly the minimum distance is kept
        hit_reg <= sum < {{(ucf_pkg::SQ_W + 1 - ucf_pkg::LIMIT_W){1'b0}}, limit};
    end

    assign busy      = v1_reg | v2_reg | v3_reg;
    assign res_valid = v3_reg;
    assign res_hit   = hit_reg;

endmodule

FILE: sv/unique_circle_filter_unit.sv
// Circle duplicate filter.
// Input channel (s_*): one word per detected circle; tdata carries center_x,
// center_y and radius, tuser[0] marks the first circle of a set and empties
// the table before that circle is checked.
// Result channel (m_*): one word per input word with status (accepted,
// duplicate, table full), the slot written and the running unique count.
// cfg_we/cfg_wdata write the minimum center distance; its square is kept.
// Each circle is compared against the stored centers one per cycle through a
// shared three-stage distance unit fed from the center table of 16 entries.
// With an empty table a word goes straight to its decision; otherwise its
// result is decided once the last compare has left the distance unit. Words
// are handled one at a time: the input closes from acceptance to the decision.
// The result sits in an output register; the next word is accepted while it
// waits, but a new result is held back until the receiver takes the old one.
// Reset empties the table, drops any pending result and sets the minimum
// distance to 10. Table contents themselves are not cleared.
module unique_circle_filter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // center_x[11:0], center_y[23:12], radius[31:24]
    input  logic [ucf_pkg::IN_DATA_W-1:0]       s_tdata,
    // first_of_set[0]
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // status[1:0], slot[5:2], unique_count[10:6], zero[15:11]
    output logic [ucf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [ucf_pkg::DIST_W-1:0]          cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam int CNT_W = ucf_pkg::CNT_W;
    localparam int IDX_W = ucf_pkg::IDX_W;

    logic [1:0]                          state_reg, state_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    scan_reg, scan_next;
    logic                                dup_reg, dup_next;
    logic [ucf_pkg::LIMIT_W-1:0]         limit_reg;
    logic [ucf_pkg::COORD_W-1:0]         cx_reg;
    logic [ucf_pkg::COORD_W-1:0]         cy_reg;
    logic [ucf_pkg::RADIUS_W-1:0]        r_reg;
    logic                                rd_valid_reg;
    logic [ucf_pkg::COORD_W-1:0]         rd_x_reg;
    logic [ucf_pkg::COORD_W-1:0]         rd_y_reg;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [ucf_pkg::OUT_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic [ucf_pkg::COORD_W-1:0]         mem_x [ucf_pkg::TABLE_DEPTH];
    logic [ucf_pkg::COORD_W-1:0]         mem_y [ucf_pkg::TABLE_DEPTH];
    logic [ucf_pkg::RADIUS_W-1:0]        mem_r [ucf_pkg::TABLE_DEPTH];

    logic                                accept;
    logic                                issue;
    logic                                decide;
    logic                                wr_en;
    logic                                table_full;
    logic                                dist_busy;
    logic                                res_valid;
    logic                                res_hit;
    ucf_pkg::status_t                    status;
    logic [ucf_pkg::SLOT_W-1:0]          slot;
    logic [ucf_pkg::UCOUNT_W-1:0]        ucount;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign table_full = (count_reg == CNT_W'(ucf_pkg::TABLE_DEPTH));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        dup_next      = dup_reg | (res_valid & res_hit);
        issue         = 1'b0;
        decide        = 1'b0;
        wr_en         = 1'b0;
        status        = ucf_pkg::STATUS_ACCEPTED;
        slot          = '0;
        ucount        = ucf_pkg::UCOUNT_W'(count_reg);
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    count_next = s_tuser[0] ? '0 : count_reg;
                    scan_next  = '0;
                    dup_next   = 1'b0;
                    state_next = (count_next == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue     = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (scan_next == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last compare, and for room in the output register
                if (!rd_valid_reg && !dist_busy && (!m_tvalid_reg || m_tready)) begin
                    decide = 1'b1;
                    if (dup_reg) begin
                        status = ucf_pkg::STATUS_DUPLICATE;
                    end else if (table_full) begin
                        status = ucf_pkg::STATUS_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        slot       = ucf_pkg::SLOT_W'(count_reg);
                        count_next = count_reg + 1'b1;
                        ucount     = ucf_pkg::UCOUNT_W'(count_next);
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ucf_pkg::OUT_DATA_W'({ucount, slot, status});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            dup_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= ucf_pkg::LIMIT_W'(ucf_pkg::MIN_DIST_RESET *
                                              ucf_pkg::MIN_DIST_RESET);
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            dup_reg      <= dup_next;
            rd_valid_reg <= issue;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata * cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            cx_reg <= s_tdata[ucf_pkg::CX_LSB +: ucf_pkg::COORD_W];
            cy_reg <= s_tdata[ucf_pkg::CY_LSB +: ucf_pkg::COORD_W];
            r_reg  <= s_tdata[ucf_pkg::RAD_LSB +: ucf_pkg::RADIUS_W];
        end
    end

    // center table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[count_reg[IDX_W-1:0]] <= cx_reg;
            mem_y[count_reg[IDX_W-1:0]] <= cy_reg;
            mem_r[count_reg[IDX_W-1:0]] <= r_reg;
        end
        rd_x_reg <= mem_x[scan_reg[IDX_W-1:0]];
        rd_y_reg <= mem_y[scan_reg[IDX_W-1:0]];
    end

    ucf_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .sx        (rd_x_reg),
        .sy        (rd_y_reg),
        .limit     (limit_reg),
        .busy      (dist_busy),
        .res_valid (res_valid),
        .res_hit   (res_hit)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/ucf_checker.sv
module ucf_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ucf_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready
);

    logic [ucf_pkg::STATUS_W-1:0] st;
    logic [ucf_pkg::SLOT_W-1:0]   sl;
    logic [ucf_pkg::UCOUNT_W-1:0] uc;

    assign st = m_tdata[ucf_pkg::STATUS_LSB +: ucf_pkg::STATUS_W];
    assign sl = m_tdata[ucf_pkg::SLOT_LSB +: ucf_pkg::SLOT_W];
    assign uc = m_tdata[ucf_pkg::UCOUNT_LSB +: ucf_pkg::UCOUNT_W];

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st != ucf_pkg::STATUS_UNUSED)
        else $error("unused status code");

    // a stored circle lands in the slot just below the new count
    a_slot_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ucf_pkg::STATUS_ACCEPTED
            |-> uc == ucf_pkg::UCOUNT_W'({1'b0, sl} + 1'b1))
        else $error("slot and unique count disagree");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ucf_pkg::STATUS_ACCEPTED |-> sl == '0)
        else $error("nonzero slot on a circle not stored");

endmodule

bind unique_circle_filter_unit ucf_checker u_ucf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
